@@ rtl/s2i_pkg.sv @@
// Shared types, constants and the digit decoder for the string-to-integer parser.
`timescale 1ns / 1ps

package s2i_pkg;

    // Field widths fixed by the interface
    localparam int CHAR_BITS     = 8;
    localparam int BASE_BITS     = 6;
    localparam int VALUE_BITS    = 64;
    localparam int CONSUMED_BITS = 16;

    // Default width of the character position counter
    localparam int POSITION_BITS_DEF = 16;

    // Depth of the queue between the classifier and the accumulator
    localparam int QUEUE_DEPTH = 4;

    // Largest reported consumed count
    localparam logic [CONSUMED_BITS-1:0] CONSUMED_MAX = '1;

    // Radix values
    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

    // Digit code for a character that is no digit at all (above every radix)
    localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd63;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOW_X   = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UP_X    = 8'h58;

    // One queue entry: a digit to fold in and/or the end of a string
    typedef struct packed {
        logic                     last;
        logic                     digit_en;
        logic [BASE_BITS-1:0]     digit;
        logic [BASE_BITS-1:0]     base;
        logic                     negative;
        logic [CONSUMED_BITS-1:0] consumed;
    } q_entry_t;

    // Case-insensitive digit value, DIGIT_NONE for anything else
    function automatic logic [BASE_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] ch);
        logic [CHAR_BITS-1:0] d;
        begin
            d = CHAR_BITS'(DIGIT_NONE);
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                d = ch - CH_ZERO;
            end
            else if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
            begin
                d = ch - CH_LOW_A + 8'd10;
            end
            else if (ch >= CH_UP_A && ch <= CH_UP_Z)
            begin
                d = ch - CH_UP_A + 8'd10;
            end
            return d[BASE_BITS-1:0];
        end
    endfunction

endpackage

@@ rtl/s2i_front.sv @@
// Character classifier: whitespace, sign, prefix and zero skipping, position count.
`timescale 1ns / 1ps

module s2i_front
    import s2i_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  logic [CHAR_BITS-1:0] char_code,
    input  logic                 last_char,
    input  logic                 number_base_we,
    input  logic [BASE_BITS-1:0] number_base_wdata,
    input  logic                 q_full,
    output logic                 q_push,
    output q_entry_t             q_wdata
);

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGN   = 3'd1,
        PH_PRE    = 3'd2,
        PH_PREX   = 3'd3,
        PH_ZEROS  = 3'd4,
        PH_DIGITS = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    phase_t                   phase_reg, phase_next;
    logic                     neg_reg, neg_next;
    logic [BASE_BITS-1:0]     base_reg, base_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [BASE_BITS-1:0]     number_base_reg;

    logic                     accept;
    logic                     taken;
    logic                     settled;
    logic                     take_digit;
    logic [BASE_BITS-1:0]     dval;
    logic [BASE_BITS-1:0]     base_clamped;
    logic [32:0]              pos_wide;

    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;
    assign dval      = digit_value(char_code);
    assign base_clamped = (number_base_reg > BASE_MAX) ? BASE_MAX : number_base_reg;

    // Walk the phases this character passes through until one settles it
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        taken      = 1'b0;
        settled    = 1'b0;
        take_digit = 1'b0;

        if (phase_next == PH_WS)
        begin
            if (char_code == CH_SPACE || char_code == CH_TAB)
            begin
                taken   = 1'b1;
                settled = 1'b1;
            end
            else
            begin
                phase_next = PH_SIGN;
            end
        end

        if (!settled && phase_next == PH_SIGN)
        begin
            phase_next = PH_PRE;
            if (char_code == CH_MINUS)
            begin
                neg_next = 1'b1;
                taken    = 1'b1;
                settled  = 1'b1;
            end
            else if (char_code == CH_PLUS)
            begin
                taken   = 1'b1;
                settled = 1'b1;
            end
        end

        if (!settled && phase_next == PH_PRE)
        begin
            if (base_clamped == BASE_AUTO)
            begin
                if (char_code == CH_ZERO)
                begin
                    base_next  = BASE_OCT;
                    phase_next = PH_PREX;
                    taken      = 1'b1;
                    settled    = 1'b1;
                end
                else
                begin
                    base_next  = BASE_DEC;
                    phase_next = PH_ZEROS;
                end
            end
            else if (base_clamped == BASE_HEX)
            begin
                base_next = BASE_HEX;
                if (char_code == CH_ZERO)
                begin
                    phase_next = PH_PREX;
                    taken      = 1'b1;
                    settled    = 1'b1;
                end
                else
                begin
                    phase_next = PH_ZEROS;
                end
            end
            else
            begin
                base_next  = base_clamped;
                phase_next = PH_ZEROS;
                if (base_clamped == BASE_OCT && char_code == CH_ZERO)
                begin
                    taken   = 1'b1;
                    settled = 1'b1;
                end
            end
        end

        if (!settled && phase_next == PH_PREX)
        begin
            phase_next = PH_ZEROS;
            if (char_code == CH_LOW_X || char_code == CH_UP_X)
            begin
                base_next = BASE_HEX;
                taken     = 1'b1;
                settled   = 1'b1;
            end
        end

        if (!settled && phase_next == PH_ZEROS)
        begin
            if (char_code == CH_ZERO)
            begin
                taken   = 1'b1;
                settled = 1'b1;
            end
            else
            begin
                phase_next = PH_DIGITS;
            end
        end

        if (!settled && phase_next == PH_DIGITS)
        begin
            if (dval < base_next)
            begin
                take_digit = 1'b1;
                taken      = 1'b1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
            settled = 1'b1;
        end
    end

    // Saturating position, and its 16-bit report
    always_comb
    begin
        pos_next = pos_reg;
        if (taken && pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
        pos_wide = 33'(pos_next);
    end

    // Queue entry for a digit or the end of a string
    always_comb
    begin
        q_push           = accept && (take_digit || last_char);
        q_wdata.last     = last_char;
        q_wdata.digit_en = take_digit;
        q_wdata.digit    = dval;
        q_wdata.base     = base_next;
        q_wdata.negative = neg_next;
        q_wdata.consumed = (pos_wide > 33'(CONSUMED_MAX)) ? CONSUMED_MAX
                                                          : pos_wide[CONSUMED_BITS-1:0];
    end

    // Parse state and radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WS;
            neg_reg         <= 1'b0;
            base_reg        <= BASE_AUTO;
            pos_reg         <= '0;
            number_base_reg <= BASE_DEC;
        end
        else
        begin
            if (number_base_we)
            begin
                number_base_reg <= number_base_wdata;
            end
            if (accept)
            begin
                if (last_char)
                begin
                    phase_reg <= PH_WS;
                    neg_reg   <= 1'b0;
                    base_reg  <= BASE_AUTO;
                    pos_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    base_reg  <= base_next;
                    pos_reg   <= pos_next;
                end
            end
        end
    end

endmodule

@@ rtl/s2i_queue.sv @@
// Short queue of digit and end-of-string entries between classifier and accumulator.
`timescale 1ns / 1ps

module s2i_queue
    import s2i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    q_entry_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [CNT_BITS-1:0]  count_reg;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

@@ rtl/s2i_back.sv @@
// Accumulator: multiply-add of digits, result register with sign applied on output.
`timescale 1ns / 1ps

module s2i_back
    import s2i_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  q_entry_t                 q_head,
    output logic                     q_pop,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [VALUE_BITS-1:0]    value,
    output logic [CONSUMED_BITS-1:0] consumed
);

    logic [VALUE_BITS-1:0]           acc_reg;
    logic [VALUE_BITS+BASE_BITS-1:0] prod;
    logic [VALUE_BITS-1:0]           acc_next;

    logic                            out_valid_reg;
    logic [VALUE_BITS-1:0]           out_mag_reg;
    logic                            out_neg_reg;
    logic [CONSUMED_BITS-1:0]        out_cons_reg;

    logic                            out_free;

    assign out_free = !out_valid_reg || !res_stall;
    assign q_pop    = !q_empty && (!q_head.last || out_free);

    // Fold one digit into the running value, modulo 2^64
    always_comb
    begin
        prod     = acc_reg * q_head.base;
        acc_next = acc_reg;
        if (q_head.digit_en)
        begin
            acc_next = prod[VALUE_BITS-1:0] + VALUE_BITS'(q_head.digit);
        end
    end

    // Accumulator and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop && q_head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                if (q_head.last)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.last)
        begin
            out_mag_reg  <= acc_next;
            out_neg_reg  <= q_head.negative;
            out_cons_reg <= q_head.consumed;
        end
    end

    assign res_valid = out_valid_reg;
    assign value     = out_neg_reg ? (VALUE_BITS'(0) - out_mag_reg) : out_mag_reg;
    assign consumed  = out_cons_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |-> !(q_pop && q_head.last))
        else $error("held result overwritten");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |=> (acc_reg == '0))
        else $error("accumulator not cleared after end of string");

endmodule

@@ rtl/string_to_integer_parser.sv @@
// Streaming strtoull-style parser: top level joining classifier, queue and accumulator.
// Throughput: one character beat per cycle, sustained while the result side takes results.
// On an accepted last_char beat the classifier writes the queue; the accumulator then pops
// that entry and registers the result, which raises res_valid.
// The classifier and the 4-entry queue set the rate; src_stall rises only with the queue full.
// Reset (rst_n, asynchronous, active low) clears parse state and sets the radix to 10.
`timescale 1ns / 1ps

module string_to_integer_parser
    import s2i_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     number_base_we,
    input  logic [BASE_BITS-1:0]     number_base_wdata,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  logic [CHAR_BITS-1:0]     char_code,
    input  logic                     last_char,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [VALUE_BITS-1:0]    value,
    output logic [CONSUMED_BITS-1:0] consumed
);

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t q_wdata;
    q_entry_t q_head;

    // Classifier
    s2i_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .src_valid         (src_valid),
        .src_stall         (src_stall),
        .char_code         (char_code),
        .last_char         (last_char),
        .number_base_we    (number_base_we),
        .number_base_wdata (number_base_wdata),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_wdata           (q_wdata)
    );

    // Decoupling queue
    s2i_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    // Accumulator and result
    s2i_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .value     (value),
        .consumed  (consumed)
    );

endmodule

@@ bench/s2i_checker.sv @@
// Scoreboard for the string-to-integer parser: predicts each result and compares it.
`timescale 1ns / 1ps

module s2i_checker
    import s2i_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     number_base_we,
    input  logic [BASE_BITS-1:0]     number_base_wdata,
    input  logic                     src_valid,
    input  logic                     src_stall,
    input  logic [CHAR_BITS-1:0]     char_code,
    input  logic                     last_char,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [VALUE_BITS-1:0]    value,
    input  logic [CONSUMED_BITS-1:0] consumed,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    localparam int NO_DIGIT    = 99;
    localparam int SHOW_LIMIT  = 10;

    // Parse stages, in the order a string passes through them
    typedef enum logic [2:0] {
        SCAN_BLANKS,
        SCAN_SIGN,
        SCAN_PREFIX,
        SCAN_PREFIX_X,
        SCAN_ZEROS,
        SCAN_DIGITS,
        SCAN_STOPPED
    } scan_phase_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    number;
        logic [CONSUMED_BITS-1:0] count;
    } parsed_number_t;

    scan_phase_t              scan_phase;
    logic [VALUE_BITS-1:0]    running_sum;
    logic                     minus_seen;
    logic [BASE_BITS-1:0]     radix;
    logic [POSITION_BITS-1:0] chars_taken;
    logic [BASE_BITS-1:0]     base_setting;
    parsed_number_t           expected_numbers[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    // Digit weight of a byte, letters folded to lower case
    function automatic int char_weight(input logic [CHAR_BITS-1:0] ch);
        logic [CHAR_BITS-1:0] folded;
        folded = ch | 8'h20;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            return int'(ch - CH_ZERO);
        if (folded >= CH_LOW_A && folded <= CH_LOW_Z)
            return int'(folded - CH_LOW_A) + 10;
        return NO_DIGIT;
    endfunction

    task automatic clear_string();
        scan_phase  = SCAN_BLANKS;
        running_sum = '0;
        minus_seen  = 1'b0;
        radix       = '0;
        chars_taken = '0;
    endtask

    // Advance the parse by one byte; a flagged last byte yields a number
    task automatic take_char(input logic [CHAR_BITS-1:0] ch, input logic final_byte);
        logic                 used;
        logic                 settled;
        int                   weight;
        logic [BASE_BITS-1:0] clipped;
        longint unsigned      wide_count;
        parsed_number_t       outcome;
        used    = 1'b0;
        settled = 1'b0;
        while (!settled)
        begin
            case (scan_phase)
                SCAN_BLANKS:
                begin
                    if (ch == CH_SPACE || ch == CH_TAB)
                    begin
                        used    = 1'b1;
                        settled = 1'b1;
                    end
                    else
                    begin
                        scan_phase = SCAN_SIGN;
                    end
                end
                SCAN_SIGN:
                begin
                    scan_phase = SCAN_PREFIX;
                    if (ch == CH_MINUS || ch == CH_PLUS)
                    begin
                        minus_seen = (ch == CH_MINUS);
                        used       = 1'b1;
                        settled    = 1'b1;
                    end
                end
                SCAN_PREFIX:
                begin
                    // radix is latched here; above 36 counts as 36
                    clipped = (base_setting > BASE_MAX) ? BASE_MAX : base_setting;
                    if (clipped == BASE_AUTO)
                    begin
                        if (ch == CH_ZERO)
                        begin
                            radix      = BASE_OCT;
                            scan_phase = SCAN_PREFIX_X;
                            used       = 1'b1;
                            settled    = 1'b1;
                        end
                        else
                        begin
                            radix      = BASE_DEC;
                            scan_phase = SCAN_ZEROS;
                        end
                    end
                    else if (clipped == BASE_HEX)
                    begin
                        radix = BASE_HEX;
                        if (ch == CH_ZERO)
                        begin
                            scan_phase = SCAN_PREFIX_X;
                            used       = 1'b1;
                            settled    = 1'b1;
                        end
                        else
                        begin
                            scan_phase = SCAN_ZEROS;
                        end
                    end
                    else
                    begin
                        radix      = clipped;
                        scan_phase = SCAN_ZEROS;
                        if (clipped == BASE_OCT && ch == CH_ZERO)
                        begin
                            used    = 1'b1;
                            settled = 1'b1;
                        end
                    end
                end
                SCAN_PREFIX_X:
                begin
                    scan_phase = SCAN_ZEROS;
                    if (ch == CH_LOW_X || ch == CH_UP_X)
                    begin
                        radix   = BASE_HEX;
                        used    = 1'b1;
                        settled = 1'b1;
                    end
                end
                SCAN_ZEROS:
                begin
                    if (ch == CH_ZERO)
                    begin
                        used    = 1'b1;
                        settled = 1'b1;
                    end
                    else
                    begin
                        scan_phase = SCAN_DIGITS;
                    end
                end
                SCAN_DIGITS:
                begin
                    weight = char_weight(ch);
                    if (weight < int'(radix))
                    begin
                        running_sum = running_sum * VALUE_BITS'(radix) + VALUE_BITS'(weight);
                        used        = 1'b1;
                    end
                    else
                    begin
                        scan_phase = SCAN_STOPPED;
                    end
                    settled = 1'b1;
                end
                default:
                begin
                    settled = 1'b1;
                end
            endcase
        end

        // position saturates rather than wraps
        if (used && chars_taken != '1)
            chars_taken = chars_taken + 1'b1;

        if (final_byte)
        begin
            wide_count     = longint'(chars_taken);
            outcome.number = minus_seen ? ('0 - running_sum) : running_sum;
            outcome.count  = (wide_count > longint'(CONSUMED_MAX)) ? CONSUMED_MAX
                                                                 : wide_count[CONSUMED_BITS-1:0];
            expected_numbers.push_back(outcome);
            clear_string();
        end
    endtask

    // Watch the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        parsed_number_t want;
        if (!rst_n)
        begin
            clear_string();
            base_setting = BASE_DEC;
            expected_numbers.delete();
            pending = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (expected_numbers.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%0t: result with nothing outstanding: value=%h consumed=%0d",
                                 $realtime, value, consumed);
                end
                else
                begin
                    want    = expected_numbers.pop_front();
                    checked = checked + 1;
                    if (want.number !== value || want.count !== consumed)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= SHOW_LIMIT)
                            $display("%0t: mismatch: value exp %h got %h, consumed exp %0d got %0d",
                                     $realtime, want.number, value, want.count, consumed);
                    end
                end
            end

            if (number_base_we)
                base_setting = number_base_wdata;

            if (src_valid && !src_stall)
                take_char(char_code, last_char);

            pending = expected_numbers.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the parser bench: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import s2i_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SETTLE_CYCLES    = 10;
    localparam int RANDOM_CHARS     = 1000;
    localparam int IDLE_PERCENT     = 23;
    localparam int NUM_PHASES       = 12;
    localparam int CALM_PHASE       = 4;

    logic                     clk               = 1'b0;
    logic                     rst_n             = 1'b0;
    logic                     number_base_we    = 1'b0;
    logic [BASE_BITS-1:0]     number_base_wdata = BASE_DEC;
    logic                     src_valid         = 1'b0;
    logic [CHAR_BITS-1:0]     char_code         = '0;
    logic                     last_char         = 1'b0;
    logic                     res_stall         = 1'b0;
    logic                     src_stall;
    logic                     res_valid;
    logic [VALUE_BITS-1:0]    value;
    logic [CONSUMED_BITS-1:0] consumed;

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   chars_sent   = 0;
    int                   strings_sent = 0;
    int                   base_writes  = 0;
    int                   quiet_cycles = 0;
    bit                   no_idling    = 1'b0;
    logic [BASE_BITS-1:0] cur_base     = BASE_DEC;

    initial
    begin
        forever #2 clk = ~clk;
    end

    string_to_integer_parser i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .number_base_we    (number_base_we),
        .number_base_wdata (number_base_wdata),
        .src_valid         (src_valid),
        .src_stall         (src_stall),
        .char_code         (char_code),
        .last_char         (last_char),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .value             (value),
        .consumed          (consumed)
    );

    s2i_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .number_base_we    (number_base_we),
        .number_base_wdata (number_base_wdata),
        .src_valid         (src_valid),
        .src_stall         (src_stall),
        .char_code         (char_code),
        .last_char         (last_char),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .value             (value),
        .consumed          (consumed),
        .fail_count        (fail_count),
        .pending           (pending),
        .checked           (checked)
    );

    // Result side back-pressure
    always @(negedge clk)
    begin
        res_stall <= !no_idling && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog: ends the run after too long without any beat
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (res_valid && !res_stall) || number_base_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("tb_top failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit take_break();
        return !no_idling && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // One character beat; entered and left at a falling edge
    task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic final_byte);
        while (take_break())
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        char_code <= ch;
        last_char <= final_byte;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_string(input logic [CHAR_BITS-1:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
        strings_sent++;
    endtask

    task automatic send_text(input string t);
        logic [CHAR_BITS-1:0] text[$];
        for (int i = 0; i < t.len(); i++)
            text.push_back(t[i]);
        send_string(text);
    endtask

    // Radix change only once the parser has drained
    task automatic set_base(input logic [BASE_BITS-1:0] b);
        src_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        number_base_we    <= 1'b1;
        number_base_wdata <= b;
        @(negedge clk);
        number_base_we <= 1'b0;
        cur_base = b;
        base_writes++;
    endtask

    // Mostly well-formed numbers with random content, some pure noise
    task automatic random_string(output logic [CHAR_BITS-1:0] text[$]);
        int                   clipped;
        int                   weight;
        int                   pick;
        logic [CHAR_BITS-1:0] letter_base;
        text = {};
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(CHAR_BITS'($urandom_range(0, 255)));
            return;
        end
        clipped = (cur_base > BASE_MAX) ? int'(BASE_MAX) : int'(cur_base);

        repeat ($urandom_range(0, 2)) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        pick = $urandom_range(0, 3);
        if (pick == 0)
            text.push_back(CH_MINUS);
        else if (pick == 1)
            text.push_back(CH_PLUS);

        // base prefix, where the radix allows one
        pick = $urandom_range(0, 3);
        if (clipped == int'(BASE_AUTO) || clipped == int'(BASE_HEX))
        begin
            if (pick != 0)
                text.push_back(CH_ZERO);
            if (pick == 2)
                text.push_back(CH_LOW_X);
            else if (pick == 3)
                text.push_back(CH_UP_X);
        end
        else if (clipped == int'(BASE_OCT) && pick < 2)
        begin
            text.push_back(CH_ZERO);
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(CH_ZERO);

        // digits of the radix (0 to 15 under automatic radix), letters in either case
        repeat ($urandom_range(0, 22))
        begin
            weight      = (clipped == 0) ? $urandom_range(0, 15) : $urandom_range(0, clipped - 1);
            letter_base = $urandom_range(1) ? CH_LOW_A : CH_UP_A;
            text.push_back(weight < 10 ? CHAR_BITS'(CH_ZERO + weight)
                                       : CHAR_BITS'(letter_base + weight - 10));
        end

        // trailing bytes after the stop point
        if ($urandom_range(99) < 40)
            repeat ($urandom_range(1, 3)) text.push_back(CHAR_BITS'($urandom_range(0, 255)));
        if (text.size() == 0)
            text.push_back(CHAR_BITS'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [CHAR_BITS-1:0] text[$];
        logic [BASE_BITS-1:0] phase_bases[$];
        int                   target;

        phase_bases = {BASE_AUTO, BASE_HEX, BASE_OCT, BASE_DEC, 6'd1, 6'd2, BASE_MAX,
                       6'd63, 6'd37};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // blanks, sign, stop characters, high byte, NUL terminator
        send_text(" \t-5");
        send_text("+:");
        send_text("9?1");
        text = {8'hFF};
        send_string(text);
        text = {8'h37, 8'h00, 8'h33};
        send_string(text);

        // prefixes under automatic, hex and octal radix
        set_base(BASE_AUTO);
        send_text("0x1F");
        send_text("017");
        set_base(BASE_HEX);
        send_text("0Xa");
        set_base(BASE_OCT);
        send_text("08");

        // radix one and a register value beyond 36
        set_base(6'd1);
        send_text("001");
        set_base(6'd63);
        send_text("zZ");

        // random phases, one radix each; one phase runs with no idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_base(p < phase_bases.size() ? phase_bases[p] : BASE_BITS'($urandom_range(0, 63)));
            no_idling = (p == CALM_PHASE);
            target    = chars_sent + RANDOM_CHARS / NUM_PHASES;
            while (chars_sent < target)
            begin
                random_string(text);
                send_string(text);
            end
        end
        no_idling = 1'b0;

        // drain
        src_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("summary: %0d strings, %0d characters, %0d results checked",
                 strings_sent, chars_sent, checked);
        $display("summary: %0d radix writes incl. auto, 1, 36 and 63; one stretch with no idling",
                 base_writes);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/s2i_pkg.sv
rtl/s2i_front.sv
rtl/s2i_queue.sv
rtl/s2i_back.sv
rtl/string_to_integer_parser.sv
bench/s2i_checker.sv
bench/tb_top.sv
